@@ rtl/core/kvmt_pkg.sv @@
// ----------------------------------------------------------------------------
// Key/value memo table package
// Shared types, constants and controller codes for the memo table core.
// ----------------------------------------------------------------------------
package kvmt_pkg;

  // Field widths fixed by the item format.
  localparam int KEY_W = 64;
  localparam int VAL_W = 32;

  // Default number of table entries (power of two).
  localparam int DEF_TABLE_ENTRIES = 512;

  // Input item.
  typedef struct packed {
    logic [KEY_W-1:0] lookup_key;
    logic [VAL_W-1:0] fill_value;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [VAL_W-1:0] result_value;
    logic             was_hit;
  } out_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WRITE,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // latch a new input item and restart the scan
    logic scan;      // issue the next table read
    logic set_zero;  // result is zero, no hit
    logic set_hit;   // result is the value read from the matching entry
    logic write;     // store the pair and take the fill value as result
    logic load_out;  // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic key_zero;  // latched key is zero
    logic hit;       // the entry read last cycle matches the key
    logic miss;      // all filled entries were compared without a match
  } sts_t;

endpackage

@@ rtl/core/kvmt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module kvmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

@@ rtl/core/kvmt_dp.sv @@
// ----------------------------------------------------------------------------
// Memo table datapath
// Holds the item, the key and value memories, the fill count, the scan
// counter with its compare stage, and the result and output registers.
// ----------------------------------------------------------------------------
module kvmt_dp #(
  parameter int TABLE_ENTRIES = kvmt_pkg::DEF_TABLE_ENTRIES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  kvmt_pkg::in_t  in_data,
  input  kvmt_pkg::cmd_t cmd,
  output kvmt_pkg::sts_t sts,
  output kvmt_pkg::out_t out_data
);

  import kvmt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             pend_r, pend_nxt;
  logic [VAL_W-1:0] res_val_r, res_val_nxt;
  logic             res_hit_r, res_hit_nxt;
  out_t             out_r;

  logic             issue;
  logic             full;
  logic             match;
  logic [IDX_W-1:0] wr_slot;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;

  // Key and value memories share the scan address and the write address.
  kvmt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk    (clk),
    .we     (cmd.write),
    .waddr  (wr_slot),
    .wdata  (key_r),
    .raddr  (scan_r[IDX_W-1:0]),
    .rdata_r(rd_key)
  );

  kvmt_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_ENTRIES)) u_val_ram (
    .clk    (clk),
    .we     (cmd.write),
    .waddr  (wr_slot),
    .wdata  (val_r),
    .raddr  (scan_r[IDX_W-1:0]),
    .rdata_r(rd_val)
  );

  // Scan and compare: one read is issued per cycle while filled entries
  // remain, and the data of the previous read is compared this cycle.
  always_comb begin
    full  = (fill_r == CNT_W'(TABLE_ENTRIES));
    issue = cmd.scan && (scan_r != fill_r);
    match = pend_r && (rd_key == key_r);

    scan_nxt = scan_r;
    pend_nxt = issue;
    if (cmd.accept) begin
      scan_nxt = '0;
      pend_nxt = 1'b0;
    end else if (issue) begin
      scan_nxt = scan_r + CNT_W'(1);
    end

    sts.key_zero = (key_r == '0);
    sts.hit      = match;
    sts.miss     = (scan_r == fill_r) && !match;
  end

  // A miss fills the next free slot, or the key's home slot once full.
  always_comb begin
    wr_slot  = full ? key_r[IDX_W-1:0] : fill_r[IDX_W-1:0];
    fill_nxt = fill_r;
    if (cmd.write && !full) begin
      fill_nxt = fill_r + CNT_W'(1);
    end
  end

  // Result selection.
  always_comb begin
    res_val_nxt = res_val_r;
    res_hit_nxt = res_hit_r;
    if (cmd.set_zero) begin
      res_val_nxt = '0;
      res_hit_nxt = 1'b0;
    end else if (cmd.set_hit) begin
      res_val_nxt = rd_val;
      res_hit_nxt = 1'b1;
    end else if (cmd.write) begin
      res_val_nxt = val_r;
      res_hit_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      scan_r <= '0;
      pend_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      scan_r <= scan_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r <= in_data.lookup_key;
      val_r <= in_data.fill_value;
    end
    res_val_r <= res_val_nxt;
    res_hit_r <= res_hit_nxt;
    if (cmd.load_out) begin
      out_r.result_value <= res_val_r;
      out_r.was_hit      <= res_hit_r;
    end
  end

  assign out_data = out_r;

endmodule

@@ rtl/core/kvmt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Memo table controller
// Sequences accept, search, write-back and result transfer, and owns the
// handshake flags of both channels.
// ----------------------------------------------------------------------------
module kvmt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  kvmt_pkg::sts_t sts,
  output kvmt_pkg::cmd_t cmd
);

  import kvmt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts.key_zero) begin
          cmd.set_zero = 1'b1;
          state_nxt    = ST_FINISH;
        end else if (sts.hit) begin
          cmd.set_hit = 1'b1;
          state_nxt   = ST_FINISH;
        end else if (sts.miss) begin
          state_nxt = ST_WRITE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // The result moves out once the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = cmd.load_out || (out_valid_r && !out_ready);
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/key_value_memo_table_core.sv @@
// ----------------------------------------------------------------------------
// Key/value memo table core
// Fully associative memo table keyed by a 64-bit key with linear search.
// ----------------------------------------------------------------------------
// Search: a zero key skips the scan, a hit ends the scan at the first matching slot,
// and a miss scans every filled entry before the pair is written back.
// Flow: one item at a time; the next transfer can be taken in the cycle after the
// result is loaded (loading waits while an earlier result is held).
// Reset: rst_n (synchronous) empties the table by clearing the fill count;
// no clearing pass runs, and the block accepts an item right after reset.
module key_value_memo_table_core #(
  parameter int TABLE_ENTRIES = kvmt_pkg::DEF_TABLE_ENTRIES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  kvmt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output kvmt_pkg::out_t out_data
);

  import kvmt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller.
  kvmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  kvmt_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .out_data(out_data)
  );

endmodule

@@ verif/key_value_memo_table_core_test.sv @@
// ----------------------------------------------------------------------------
// Key/value memo table core testbench
// Drives lookups through the valid/ready input channel and checks every
// answer against a local memo table model. A short directed sequence covers
// zero keys, extreme keys and values, and repeat hits. Random lookups then
// fill the table and go on to overwrite slots once it is full. Idling of the
// sender and the receiver changes between three phases.
// ----------------------------------------------------------------------------
module key_value_memo_table_core_test;
  import kvmt_pkg::*;

  localparam int ENTRIES      = DEF_TABLE_ENTRIES;
  localparam int SLOT_W       = $clog2(ENTRIES);
  localparam int RANDOM_ITEMS = 930;
  localparam int DRAIN_CYCLES = ENTRIES + 100;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int MAX_REPORTS  = 10;

  // Memo table model and store of the answers still to come.
  class memo_table_checker;
    logic [KEY_W-1:0] model_keys [ENTRIES];
    logic [VAL_W-1:0] model_values [ENTRIES];
    int unsigned      filled;
    out_t             expected_answers [$];
    int unsigned      errors;

    function new();
      filled = 0;
      errors = 0;
    endfunction

    // Work out the answer to one lookup and update the table.
    function out_t predict_lookup(in_t item);
      out_t ans;
      int   slot;
      ans.result_value = '0;
      ans.was_hit      = 1'b0;
      if (item.lookup_key == '0) begin
        return ans;
      end
      // Lowest-numbered matching slot wins.
      for (int i = 0; i < filled; i++) begin
        if (model_keys[i] == item.lookup_key) begin
          ans.result_value = model_values[i];
          ans.was_hit      = 1'b1;
          return ans;
        end
      end
      // Miss: next free slot, or the slot picked by the key's low bits.
      if (filled >= ENTRIES) begin
        slot = int'(item.lookup_key[SLOT_W-1:0]);
      end else begin
        slot   = int'(filled);
        filled = filled + 1;
      end
      model_keys[slot]   = item.lookup_key;
      model_values[slot] = item.fill_value;
      ans.result_value   = item.fill_value;
      return ans;
    endfunction

    function void note_lookup(in_t item);
      expected_answers.push_back(predict_lookup(item));
    endfunction

    function void check_answer(out_t got);
      out_t exp_ans;
      if (expected_answers.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("unexpected answer: result_value=%h was_hit=%b",
                   got.result_value, got.was_hit);
        end
        return;
      end
      exp_ans = expected_answers.pop_front();
      if (got.result_value !== exp_ans.result_value ||
          got.was_hit !== exp_ans.was_hit) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("answer mismatch: result_value exp %h got %h, was_hit exp %b got %b",
                   exp_ans.result_value, got.result_value, exp_ans.was_hit, got.was_hit);
        end
      end
    endfunction

    function int pending();
      return expected_answers.size();
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count   = 0;

  logic [KEY_W-1:0]  seen_keys [$];
  memo_table_checker memo_sb = new();

  key_value_memo_table_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver readiness, drawn fresh every cycle.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Note every input transfer and check every result transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        memo_sb.note_lookup(in_data);
      end
      if (out_valid && out_ready) begin
        memo_sb.check_answer(out_data);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** key_value_memo_table_core: FAILED **");
      $finish;
    end
  end

  // Offer one item, called at a falling edge; returns at the falling edge
  // after the transfer.
  task automatic send_lookup(in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    seen_keys.push_back(item.lookup_key);
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic send_pair(logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    in_t item;
    item.lookup_key = key;
    item.fill_value = value;
    send_lookup(item);
  endtask

  // Random lookup: mostly fresh keys while the table fills, then more
  // repeats and low-bit collisions once it is full.
  function automatic in_t random_lookup();
    in_t         item;
    int unsigned pick;
    int unsigned zero_lim;
    int unsigned reuse_lim;
    int unsigned clash_lim;
    item.fill_value = $urandom;
    item.lookup_key = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (memo_sb.filled < ENTRIES) begin
      zero_lim  = 3;
      reuse_lim = 18;
      clash_lim = 25;
    end else begin
      zero_lim  = 5;
      reuse_lim = 50;
      clash_lim = 70;
    end
    if (pick < zero_lim) begin
      item.lookup_key = '0;
    end else if (pick < reuse_lim && seen_keys.size() > 0) begin
      item.lookup_key = seen_keys[$urandom_range(seen_keys.size() - 1)];
    end else if (pick < clash_lim && seen_keys.size() > 0) begin
      // Same slot index as a known key, different upper bits.
      item.lookup_key[SLOT_W-1:0] =
        seen_keys[$urandom_range(seen_keys.size() - 1)][SLOT_W-1:0];
    end
    return item;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed lookups: zero keys, extreme keys and values, repeat hits.
    send_idle_pct = 37;
    recv_idle_pct = 66;
    send_pair('0, '1);
    send_pair('1, '1);
    send_pair('1, '0);
    send_pair(64'd1, '0);
    send_pair(64'd1, 32'd5);
    send_pair(64'h8000_0000_0000_0000, 32'h8000_0000);
    send_pair('0, '0);
    send_pair(64'h0000_0000_0000_0200, 32'h0000_0001);
    send_pair(64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
    send_pair(64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
    send_pair(64'h8000_0000_0000_0000, 32'h1234_5678);
    send_pair(64'h0000_0000_0000_0200, 32'hFFFF_0000);
    send_pair(64'd1, 32'hDEAD_BEEF);
    send_pair(64'h0000_0001_0000_0000, 32'h0000_FFFF);
    send_pair('1, 32'h0F0F_0F0F);

    // Random lookups in three idling phases.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 66;
        recv_idle_pct = 37;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_lookup(random_lookup());
    end
    in_valid <= 1'b0;

    // Wait for the remaining answers, then watch for stray ones.
    while (memo_sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (memo_sb.errors == 0 && memo_sb.pending() == 0) begin
      $display("** key_value_memo_table_core: PASSED **");
    end else begin
      $display("** key_value_memo_table_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/kvmt_pkg.sv
rtl/core/kvmt_ram.sv
rtl/core/kvmt_dp.sv
rtl/core/kvmt_ctrl.sv
rtl/core/key_value_memo_table_core.sv
verif/key_value_memo_table_core_test.sv
